// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define CSW_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("%m: check failed");

// Clocked check that also holds during reset.
`define CSW_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("%m: check failed");

`endif

// ----- rtl/csw_pkg.sv -----
package csw_pkg;

  localparam int unsigned CoordW      = 11;
  localparam int unsigned MagW        = 10;
  localparam int unsigned ExtW        = 10;
  localparam int unsigned MaxExtent   = 1023;
  localparam int unsigned ExtentReset = 16;
  localparam int unsigned StepW       = 2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_CHECK,
    OP_REDUCE,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    CND_NO_ITEM,
    CND_SKIP,
    CND_BOTH_NZ,
    CND_OUT_FULL
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [StepW-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic ready;
    logic load;
    logic reduce;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic skip;
    logic both_nz;
  } status_t;

  localparam logic [StepW-1:0] StepIdle   = 2'd0;
  localparam logic [StepW-1:0] StepCheck  = 2'd1;
  localparam logic [StepW-1:0] StepReduce = 2'd2;
  localparam logic [StepW-1:0] StepEmit   = 2'd3;

  // Control store: jump to target when the condition holds, else fall through.
  // The emit step is the last one, so falling through wraps to idle.
  function automatic ucode_t ucode_at(logic [StepW-1:0] step);
    ucode_t uw;
    case (step)
      StepIdle:   uw = '{op: OP_LOAD,   cond: CND_NO_ITEM,  target: StepIdle};
      StepCheck:  uw = '{op: OP_CHECK,  cond: CND_SKIP,     target: StepEmit};
      StepReduce: uw = '{op: OP_REDUCE, cond: CND_BOTH_NZ,  target: StepReduce};
      StepEmit:   uw = '{op: OP_EMIT,   cond: CND_OUT_FULL, target: StepEmit};
      default:    uw = '{op: OP_LOAD,   cond: CND_NO_ITEM,  target: StepIdle};
    endcase
    return uw;
  endfunction

endpackage

// ----- rtl/csw_sequencer.sv -----
module csw_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             out_full_i,
  input  csw_pkg::status_t status_i,
  output csw_pkg::ctrl_t   ctrl_o
);
  import csw_pkg::*;

  logic [StepW-1:0] step_q, step_d;
  ucode_t           uw;
  logic             cond_hit;

  assign uw = ucode_at(step_q);

  always_comb begin
    case (uw.cond)
      CND_NO_ITEM:  cond_hit = !in_valid_i;
      CND_SKIP:     cond_hit = status_i.skip;
      CND_BOTH_NZ:  cond_hit = status_i.both_nz;
      CND_OUT_FULL: cond_hit = out_full_i;
      default:      cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (cond_hit) begin
      step_d = uw.target;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_comb begin
    ctrl_o.ready  = (uw.op == OP_LOAD);
    ctrl_o.load   = (uw.op == OP_LOAD) && in_valid_i;
    ctrl_o.reduce = (uw.op == OP_REDUCE);
    ctrl_o.emit   = (uw.op == OP_EMIT) && !out_full_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepIdle;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ----- rtl/csw_gcd_datapath.sv -----
module csw_gcd_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  csw_pkg::ctrl_t           ctrl_i,
  input  logic [csw_pkg::MagW-1:0] mag_a_i,
  input  logic [csw_pkg::MagW-1:0] mag_b_i,
  input  logic                     skip_i,
  output csw_pkg::status_t         status_o,
  output logic                     coprime_o
);
  import csw_pkg::*;

  logic [MagW-1:0] x_q, x_d, y_q, y_d;
  logic            skip_q;
  logic            any_q;

  // Binary GCD step: strip a factor of two or halve the odd difference.
  // With x zero this leaves both values unchanged; with only y zero an even x is halved.
  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (ctrl_i.load) begin
      x_d = mag_a_i;
      y_d = mag_b_i;
    end else if (ctrl_i.reduce) begin
      if (!x_q[0]) begin
        x_d = x_q >> 1;
      end else if (!y_q[0]) begin
        y_d = y_q >> 1;
      end else if (x_q >= y_q) begin
        x_d = (x_q - y_q) >> 1;
      end else begin
        y_d = (y_q - x_q) >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    if (ctrl_i.load) begin
      skip_q <= skip_i;
    end
  end

  // Marks that an item has been loaded, so the status never reads stale data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q <= 1'b0;
    end else if (ctrl_i.load) begin
      any_q <= 1'b1;
    end
  end

  // Both even (origin included) can never be coprime.
  assign status_o.skip    = !any_q || skip_q || (!x_q[0] && !y_q[0]);
  assign status_o.both_nz = (x_q != '0) && (y_q != '0);
  assign coprime_o        = any_q && !skip_q && ((x_q | y_q) == MagW'(1));

endmodule

// ----- rtl/coprime_lattice_sweep.sv -----
// Sweeps the square [-L,L]^2 and flags each point whose coordinates are coprime.
// An accepted item passes the check step, the binary GCD loop in the datapath (one
// subtract-and-halve step per cycle, bypassed for skipped points) and the emit step.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset: step counter idle, position (0,0), sweep finished, max_extent 16, no result.
module coprime_lattice_sweep (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [csw_pkg::ExtW-1:0]          cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              restart_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [csw_pkg::CoordW-1:0] first_coord_o,
  output logic signed [csw_pkg::CoordW-1:0] second_coord_o,
  output logic                              is_coprime_o,
  output logic                              sweep_done_o
);
  import csw_pkg::*;

  ctrl_t   ctrl;
  status_t status;
  logic    out_full;
  logic    coprime;

  logic [ExtW-1:0]          max_extent_q;
  logic signed [CoordW-1:0] ext_l;
  logic signed [CoordW-1:0] outer_q, outer_d, inner_q, inner_d;
  logic signed [CoordW-1:0] neg_outer, neg_inner;
  logic                     finished_q, finished_d;
  logic                     done_q, hold_d, done_d;
  logic [MagW-1:0]          mag_a, mag_b;
  logic                     out_valid_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !ctrl.ready;
  assign out_full    = out_valid_q && out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    if (32'(max_extent_q) > MaxExtent) begin
      ext_l = CoordW'(MaxExtent);
    end else begin
      ext_l = CoordW'(max_extent_q);
    end
  end

  // Next lattice point; a restart returns to (-L,-L), an advance past the end holds the position.
  always_comb begin
    outer_d = outer_q;
    inner_d = inner_q;
    hold_d  = 1'b0;
    if (restart_i) begin
      outer_d = -ext_l;
      inner_d = -ext_l;
    end else if (finished_q || (outer_q > ext_l) ||
                 ((outer_q == ext_l) && (inner_q >= ext_l))) begin
      hold_d = 1'b1;
    end else if (inner_q >= ext_l) begin
      inner_d = -ext_l;
      outer_d = outer_q + CoordW'(1);
    end else begin
      inner_d = inner_q + CoordW'(1);
    end
    done_d     = hold_d || ((outer_d == ext_l) && (inner_d >= ext_l));
    finished_d = done_d;
  end

  assign neg_outer = -outer_d;
  assign neg_inner = -inner_d;
  assign mag_a     = outer_d[CoordW-1] ? neg_outer[MagW-1:0] : outer_d[MagW-1:0];
  assign mag_b     = inner_d[CoordW-1] ? neg_inner[MagW-1:0] : inner_d[MagW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_extent_q <= ExtW'(ExtentReset);
      outer_q      <= '0;
      inner_q      <= '0;
      finished_q   <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        max_extent_q <= cfg_data_i;
      end
      if (ctrl.load) begin
        outer_q    <= outer_d;
        inner_q    <= inner_d;
        finished_q <= finished_d;
      end
      if (ctrl.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      done_q <= done_d;
    end
    if (ctrl.emit) begin
      first_coord_o  <= outer_q;
      second_coord_o <= inner_q;
      is_coprime_o   <= coprime;
      sweep_done_o   <= done_q;
    end
  end

  csw_sequencer u_sequencer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_full_i (out_full),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  csw_gcd_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .mag_a_i   (mag_a),
    .mag_b_i   (mag_b),
    .skip_i    (hold_d),
    .status_o  (status),
    .coprime_o (coprime)
  );

endmodule

// ----- rtl/csw_checker.sv -----
`include "assert_macros.svh"

module csw_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [csw_pkg::CoordW-1:0] first_coord_o,
  input logic signed [csw_pkg::CoordW-1:0] second_coord_o,
  input logic                              is_coprime_o
);
  import csw_pkg::*;

  // One item in flight: an accepted item blocks the next cycle.
  `CSW_ASSERT(a_one_in_flight, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)

  // A stalled result stays offered.
  `CSW_ASSERT(a_out_held, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> out_valid_o)

  // Two even coordinates (origin included) share a factor.
  `CSW_ASSERT(a_even_not_coprime, clk_i, rst_ni, (out_valid_o && !first_coord_o[0] && !second_coord_o[0]) |-> !is_coprime_o)

  // No result may appear out of reset.
  `CSW_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o)

endmodule

bind coprime_lattice_sweep csw_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .first_coord_o  (first_coord_o),
  .second_coord_o (second_coord_o),
  .is_coprime_o   (is_coprime_o)
);

// ----- bench/tb_coprime_lattice_sweep.sv -----
`timescale 1ns / 1ps

module tb_coprime_lattice_sweep;

  import csw_pkg::CoordW;
  import csw_pkg::ExtW;
  import csw_pkg::MaxExtent;
  import csw_pkg::ExtentReset;

  localparam int NumRows     = 28;
  localparam int RandomItems = 1930;
  localparam int DrainCycles = 40;
  localparam int CycleLimit  = 1_000_000;

  typedef struct packed {
    logic signed [CoordW-1:0] first_coord;
    logic signed [CoordW-1:0] second_coord;
    logic                     coprime;
    logic                     done;
  } lattice_point_t;

  typedef enum logic {ROW_ITEM, ROW_EXTENT} row_kind_e;

  typedef struct packed {
    row_kind_e      kind;
    logic [ExtW-1:0] extent;
    logic           restart;
    logic           typed;
    lattice_point_t want;
  } stim_row_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_BURST} stall_mode_e;

  localparam lattice_point_t NoCheck = '0;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [ExtW-1:0]          cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     restart_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [CoordW-1:0] first_coord_o;
  logic signed [CoordW-1:0] second_coord_o;
  logic                     is_coprime_o;
  logic                     sweep_done_o;

  // shadow of the block state
  int extent_val = ExtentReset;
  int outer_pos  = 0;
  int inner_pos  = 0;
  bit sweep_over = 1'b1;

  lattice_point_t pending_points[$];
  stim_row_t      directed_rows [NumRows];

  int          items_sent      = 0;
  int          restarts_sent   = 0;
  int          extents_written = 0;
  int          results_checked = 0;
  int          coprime_seen    = 0;
  int          done_seen       = 0;
  int          mismatch_count  = 0;
  int          burst_left      = 0;
  int unsigned cycle_count     = 0;
  int          hold_left       = 0;
  stall_mode_e stall_mode      = STALL_NONE;

  coprime_lattice_sweep dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .restart_i     (restart_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .first_coord_o (first_coord_o),
    .second_coord_o(second_coord_o),
    .is_coprime_o  (is_coprime_o),
    .sweep_done_o  (sweep_done_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic bit has_unit_gcd(input int a, input int b);
    int x;
    int y;
    int t;
    x = (a < 0) ? -a : a;
    y = (b < 0) ? -b : b;
    while (y != 0) begin
      t = y;
      y = x % y;
      x = t;
    end
    return x == 1;
  endfunction

  // Advances the shadow sweep by one item and returns the point it reports.
  function automatic lattice_point_t next_lattice_point(input bit restart);
    lattice_point_t pt;
    int l;
    l = (extent_val > MaxExtent) ? MaxExtent : extent_val;
    pt.coprime = 1'b0;
    pt.done    = 1'b1;
    if (restart) begin
      outer_pos = -l;
      inner_pos = -l;
    end else if (sweep_over || outer_pos > l || (outer_pos == l && inner_pos >= l)) begin
      // past the end, before any restart, or square shrunk under us: hold
      sweep_over      = 1'b1;
      pt.first_coord  = CoordW'(outer_pos);
      pt.second_coord = CoordW'(inner_pos);
      return pt;
    end else if (inner_pos >= l) begin
      inner_pos = -l;
      outer_pos = outer_pos + 1;
    end else begin
      inner_pos = inner_pos + 1;
    end
    sweep_over      = (outer_pos == l && inner_pos >= l);
    pt.first_coord  = CoordW'(outer_pos);
    pt.second_coord = CoordW'(inner_pos);
    pt.coprime      = has_unit_gcd(outer_pos, inner_pos);
    pt.done         = sweep_over;
    return pt;
  endfunction

  task automatic push_item(input bit rs, input bit typed, input lattice_point_t want);
    lattice_point_t predicted;
    in_valid_i <= 1'b1;
    restart_i  <= rs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = next_lattice_point(rs);
    pending_points.push_back(typed ? want : predicted);
    items_sent++;
    if (rs) restarts_sent++;
  endtask

  task automatic sender_pause();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // Only with the block idle: let every pending item come out first.
  task automatic write_extent(input logic [ExtW-1:0] value);
    in_valid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    extent_val = int'(value);
    extents_written++;
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 300 == 0) stall_mode <= stall_mode_e'($urandom_range(0, 2));
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_RANDOM: out_stall_i <= ($urandom_range(0, 2) == 0);
        STALL_BURST: begin
          if ($urandom_range(0, 7) == 0) begin
            hold_left   <= $urandom_range(1, 10);
            out_stall_i <= 1'b1;
          end else begin
            out_stall_i <= 1'b0;
          end
        end
        default: out_stall_i <= 1'b0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    lattice_point_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: (%0d,%0d) coprime=%0b done=%0b",
                   first_coord_o, second_coord_o, is_coprime_o, sweep_done_o);
      end else begin
        want = pending_points.pop_front();
        results_checked++;
        if (want.coprime) coprime_seen++;
        if (want.done) done_seen++;
        if (first_coord_o !== want.first_coord || second_coord_o !== want.second_coord ||
            is_coprime_o !== want.coprime || sweep_done_o !== want.done) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch on result %0d: got (%0d,%0d) coprime=%0b done=%0b,",
                     results_checked, first_coord_o, second_coord_o, is_coprime_o,
                     sweep_done_o);
            $display("  want (%0d,%0d) coprime=%0b done=%0b",
                     want.first_coord, want.second_coord, want.coprime, want.done);
          end
        end
      end
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results outstanding", CycleLimit,
             pending_points.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int          target;
    int          n;
    int          phase;
    logic [ExtW-1:0] ext;
    bit          rs;

    directed_rows = '{
      // advance straight out of reset: held origin, done
      '{ROW_ITEM,   10'd0,    1'b0, 1'b1, '{11'sd0, 11'sd0, 1'b0, 1'b1}},
      '{ROW_ITEM,   10'd0,    1'b1, 1'b1, '{-11'sd16, -11'sd16, 1'b0, 1'b0}},
      '{ROW_ITEM,   10'd0,    1'b0, 1'b0, NoCheck},
      // zero extent: restart lands on the last point
      '{ROW_EXTENT, 10'd0,    1'b0, 1'b0, NoCheck},
      '{ROW_ITEM,   10'd0,    1'b1, 1'b1, '{11'sd0, 11'sd0, 1'b0, 1'b1}},
      '{ROW_ITEM,   10'd0,    1'b0, 1'b1, '{11'sd0, 11'sd0, 1'b0, 1'b1}},
      '{ROW_EXTENT, 10'd1,    1'b0, 1'b0, NoCheck},
      '{ROW_ITEM,   10'd0,    1'b1, 1'b1, '{-11'sd1, -11'sd1, 1'b1, 1'b0}},
      '{ROW_ITEM,   10'd0,    1'b0, 1'b0, NoCheck},
      '{ROW_ITEM,   10'd0,    1'b0, 1'b0, NoCheck},
      '{ROW_ITEM,   10'd0,    1'b0, 1'b0, NoCheck},
      '{ROW_ITEM,   10'd0,    1'b0, 1'b0, NoCheck},
      '{ROW_ITEM,   10'd0,    1'b0, 1'b0, NoCheck},
      '{ROW_ITEM,   10'd0,    1'b0, 1'b0, NoCheck},
      '{ROW_ITEM,   10'd0,    1'b0, 1'b0, NoCheck},
      // now at (1,0); shrink to zero puts it past the end
      '{ROW_EXTENT, 10'd0,    1'b0, 1'b0, NoCheck},
      '{ROW_ITEM,   10'd0,    1'b0, 1'b1, '{11'sd1, 11'sd0, 1'b0, 1'b1}},
      '{ROW_EXTENT, 10'd1023, 1'b0, 1'b0, NoCheck},
      '{ROW_ITEM,   10'd0,    1'b1, 1'b1, '{-11'sd1023, -11'sd1023, 1'b0, 1'b0}},
      '{ROW_ITEM,   10'd0,    1'b0, 1'b0, NoCheck},
      '{ROW_EXTENT, 10'd2,    1'b0, 1'b0, NoCheck},
      '{ROW_ITEM,   10'd0,    1'b1, 1'b0, NoCheck},
      '{ROW_ITEM,   10'd0,    1'b0, 1'b0, NoCheck},
      '{ROW_ITEM,   10'd0,    1'b0, 1'b0, NoCheck},
      '{ROW_ITEM,   10'd0,    1'b0, 1'b0, NoCheck},
      // at (-2,1); shrink to one forces the inner wrap
      '{ROW_EXTENT, 10'd1,    1'b0, 1'b0, NoCheck},
      '{ROW_ITEM,   10'd0,    1'b0, 1'b0, NoCheck},
      '{ROW_ITEM,   10'd0,    1'b1, 1'b0, NoCheck}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_EXTENT) begin
        write_extent(directed_rows[i].extent);
      end else begin
        push_item(directed_rows[i].restart, directed_rows[i].typed, directed_rows[i].want);
        sender_pause();
      end
    end

    target = items_sent + RandomItems;
    phase  = 0;
    while (items_sent < target) begin
      if (phase == 0) begin
        ext = 10'd1023;
      end else if (phase == 1) begin
        ext = 10'd0;
      end else begin
        case ($urandom_range(0, 9))
          0: ext = ExtW'($urandom_range(0, 1023));
          // shrink under a running sweep
          1, 2: ext = (extent_val > 0) ? ExtW'($urandom_range(0, extent_val - 1)) : ExtW'(3);
          default: ext = ExtW'($urandom_range(1, 6));
        endcase
      end
      write_extent(ext);
      n = $urandom_range(40, 140);
      for (int k = 0; k < n && items_sent < target; k++) begin
        // mostly walk the sweep; restart soon once it has finished
        rs = sweep_over ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 49) == 0);
        push_item(rs, 1'b0, NoCheck);
        sender_pause();
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d items (%0d restarts) over %0d extent settings, %0d results checked",
             items_sent, restarts_sent, extents_written, results_checked);
    $display("%0d coprime points, %0d done flags, %0d cycles", coprime_seen, done_seen,
             cycle_count);
    if (mismatch_count == 0 && pending_points.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/csw_pkg.sv
rtl/csw_sequencer.sv
rtl/csw_gcd_datapath.sv
rtl/coprime_lattice_sweep.sv
rtl/csw_checker.sv
bench/tb_coprime_lattice_sweep.sv
